>>> sv/itc_pkg.sv
// Package for the three-channel interval timer: counter state type, command
// codes and the per-counter update functions. No dependencies.
package itc_pkg;

  localparam logic [1:0] CMD_READ = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_GATE = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;
  localparam logic [1:0] CTRL_PORT = 2'd3;
  localparam logic [1:0] SEL_READBACK = 2'd3;
  localparam int SETTLE_LIMIT = 4;

  localparam logic [1:0] ACC_LATCH = 2'd0;
  localparam logic [1:0] ACC_LOW = 2'd1;
  localparam logic [1:0] ACC_HIGH = 2'd2;
  localparam logic [1:0] ACC_BOTH = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE, OP_READ, OP_WRITE, OP_CTRL, OP_READBACK, OP_GATE, OP_TICK
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic [7:0] data;
    logic gate;
  } ctr_op_t;

  typedef struct packed {
    logic [15:0] count_element;
    logic [15:0] output_latch;
    logic [15:0] count_reload;
    logic [5:0] control_bits;
    logic [7:0] status_latch;
    logic latch_full;
    logic status_full;
    logic read_high_next;
    logic write_high_next;
    logic [2:0] counter_mode;
    logic gate_state;
    logic out_level;
    logic [1:0] out_phase;
    logic [15:0] phase_one_end;
    logic [1:0] phase_two_end;
  } ctr_state_t;

  localparam ctr_state_t CTR_RESET = '{
    count_element: 16'd0, output_latch: 16'd0, count_reload: 16'd0,
    control_bits: 6'h30, status_latch: 8'd0, latch_full: 1'b0,
    status_full: 1'b0, read_high_next: 1'b0, write_high_next: 1'b0,
    counter_mode: 3'd0, gate_state: 1'b0, out_level: 1'b0,
    out_phase: 2'd0, phase_one_end: 16'd0, phase_two_end: 2'd0};

  function automatic ctr_state_t settle(input ctr_state_t s_in, input logic [15:0] elapsed);
    ctr_state_t s;
    logic [15:0] e;
    logic done;
    logic signed [16:0] d;
    logic [16:0] half;
    s = s_in;
    e = elapsed;
    done = 1'b0;
    d = '0;
    half = '0;
    if (s.counter_mode != 3'd1 && s.counter_mode != 3'd5 && !s.gate_state) begin
      done = 1'b1;
    end
    for (int n = 0; n < SETTLE_LIMIT; n++) begin
      if (!done) begin
        if (s.out_phase == 2'd0) begin
          s.count_element = s.count_element - e;
          done = 1'b1;
        end else if (s.out_phase == 2'd1) begin
          d = $signed({1'b0, s.count_element}) - $signed({1'b0, s.phase_one_end});
          if ($signed({1'b0, e}) < d) begin
            s.count_element = s.count_element - e;
            done = 1'b1;
          end else if (s.counter_mode == 3'd0 || s.counter_mode == 3'd1) begin
            s.out_phase = 2'd0;
            s.count_element = s.count_element - e;
            s.out_level = 1'b1;
            done = 1'b1;
          end else begin
            e = e - d[15:0];
            s.count_element = s.phase_one_end;
            s.out_phase = 2'd2;
            s.out_level = 1'b0;
          end
        end else begin
          d = $signed({1'b0, s.count_element}) - $signed({15'd0, s.phase_two_end});
          if ($signed({1'b0, e}) < d) begin
            s.count_element = s.count_element - e;
            done = 1'b1;
          end else if (s.counter_mode == 3'd4 || s.counter_mode == 3'd5) begin
            s.out_phase = 2'd0;
            s.count_element = s.count_element - e;
            s.out_level = 1'b1;
            done = 1'b1;
          end else begin
            e = e - d[15:0];
            s.out_phase = 2'd1;
            s.out_level = 1'b1;
            s.count_element = s.count_reload;
            if (s.counter_mode == 3'd3) begin
              half = ({1'b0, s.count_reload} + 17'd1) >> 1;
              s.phase_one_end = half[15:0];
            end
          end
        end
      end
    end
    return s;
  endfunction

  function automatic ctr_state_t load_count(input ctr_state_t s_in);
    ctr_state_t s;
    logic [16:0] half;
    s = s_in;
    half = ({1'b0, s.count_reload} + 17'd1) >> 1;
    s.count_element = s.count_reload;
    s.out_phase = 2'd1;
    case (s.counter_mode)
      3'd0, 3'd1: s.phase_one_end = 16'd0;
      3'd2: begin
        s.phase_one_end = 16'd2;
        s.phase_two_end = 2'd1;
      end
      3'd3: begin
        s.phase_one_end = half[15:0] + 16'd1;
        s.phase_two_end = 2'd1;
      end
      3'd4, 3'd5: begin
        s.phase_one_end = 16'd1;
        s.phase_two_end = 2'd0;
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic ctr_state_t latch_count(input ctr_state_t s_in);
    ctr_state_t s;
    s = settle(s_in, 16'd0);
    s.read_high_next = 1'b0;
    s.output_latch = s.count_element;
    s.latch_full = 1'b1;
    return s;
  endfunction

  function automatic ctr_state_t latch_status(input ctr_state_t s_in);
    ctr_state_t s;
    s = settle(s_in, 16'd0);
    s.status_latch = {s.out_level, 1'b0, s.control_bits};
    s.status_full = 1'b1;
    return s;
  endfunction

endpackage

>>> sv/itc_in_if.sv
// Input channel of the interval timer: valid/ready handshake and the command
// payload. Depends on nothing.
interface itc_in_if;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic [1:0] port;
  logic [7:0] wr_data;
  logic [1:0] gate_select;
  logic gate_value;
  modport source(output valid, cmd, port, wr_data, gate_select, gate_value, input ready);
  modport sink(input valid, cmd, port, wr_data, gate_select, gate_value, output ready);
endinterface

>>> sv/itc_out_if.sv
// Result channel of the interval timer: valid/ready handshake, read byte and
// output levels. Depends on nothing.
interface itc_out_if;
  logic valid;
  logic ready;
  logic [7:0] rd_data;
  logic [2:0] out_levels;
  modport source(output valid, rd_data, out_levels, input ready);
  modport sink(input valid, rd_data, out_levels, output ready);
endinterface

>>> sv/itc_counter.sv
// One counter channel: its state registers and the update for one decoded
// operation per accepted transaction. Depends on itc_pkg.
module itc_counter (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  itc_pkg::ctr_op_t op,
  output logic [7:0]      rd_byte,
  output logic            out_level
);
  import itc_pkg::*;

  ctr_state_t st;
  ctr_state_t st_next;
  logic [15:0] v;
  logic [15:0] h;
  logic [15:0] lo;
  logic [15:0] hi;
  logic [7:0] b;

  always_comb begin
    st_next = st;
    rd_byte = 8'hff;
    v = '0;
    h = st.count_reload >> 1;
    b = op.data;
    lo = {st.count_reload[15:8], b};
    hi = {b, st.count_reload[7:0]};
    case (op.kind)
      OP_READ: begin
        st_next = settle(st, 16'd0);
        if (!st_next.latch_full) begin
          st_next.output_latch = st_next.count_element;
        end
        if (st_next.status_full) begin
          st_next.status_full = 1'b0;
          rd_byte = st_next.status_latch;
        end else begin
          v = st_next.output_latch;
          if (st_next.counter_mode == 3'd3) begin
            if (v > h) begin
              v = v - h;
            end
            v = v << 1;
          end
          case (st_next.control_bits[5:4])
            ACC_LOW: begin
              st_next.latch_full = 1'b0;
              rd_byte = v[7:0];
            end
            ACC_HIGH: begin
              st_next.latch_full = 1'b0;
              rd_byte = v[15:8];
            end
            ACC_BOTH: begin
              if (!st_next.read_high_next) begin
                st_next.read_high_next = 1'b1;
                rd_byte = v[7:0];
              end else begin
                st_next.latch_full = 1'b0;
                st_next.read_high_next = 1'b0;
                rd_byte = v[15:8];
              end
            end
            default: rd_byte = 8'hff;
          endcase
        end
      end
      OP_WRITE: begin
        st_next = settle(st, 16'd0);
        case (st_next.control_bits[5:4])
          ACC_LOW: begin
            st_next.count_reload = lo;
            if (st_next.counter_mode != 3'd1 && st_next.counter_mode != 3'd5) begin
              st_next = load_count(st_next);
            end
          end
          ACC_HIGH: begin
            st_next.count_reload = hi;
            if (st_next.counter_mode != 3'd1 && st_next.counter_mode != 3'd5) begin
              st_next = load_count(st_next);
            end
          end
          ACC_BOTH: begin
            if (!st_next.write_high_next) begin
              st_next.count_reload = lo;
              st_next.write_high_next = 1'b1;
              if (st_next.counter_mode == 3'd0) begin
                st_next.out_phase = 2'd0;
              end
            end else begin
              st_next.count_reload = hi;
              st_next.write_high_next = 1'b0;
              if (st_next.counter_mode != 3'd1 && st_next.counter_mode != 3'd5) begin
                st_next = load_count(st_next);
              end
            end
          end
          default: ;
        endcase
      end
      OP_CTRL: begin
        st_next = settle(st, 16'd0);
        if (b[5:4] == ACC_LATCH) begin
          st_next = latch_count(st_next);
        end else begin
          st_next.control_bits = b[5:0];
          st_next.write_high_next = 1'b0;
          st_next.counter_mode = b[2] ? {1'b0, b[2:1]} : b[3:1];
          st_next.out_level = (st_next.counter_mode != 3'd0);
        end
      end
      OP_READBACK: begin
        if (!b[5]) begin
          st_next = latch_count(st_next);
        end
        if (!b[4]) begin
          st_next = latch_status(st_next);
        end
      end
      OP_GATE: begin
        st_next = settle(st, 16'd0);
        if (st_next.gate_state != op.gate) begin
          st_next.gate_state = op.gate;
          if (st.counter_mode[1]) begin
            if (op.gate) begin
              st_next = load_count(st_next);
            end else begin
              st_next.out_level = 1'b1;
            end
          end else if (st.counter_mode[0]) begin
            if (op.gate) begin
              st_next = load_count(st_next);
            end
            if (st.counter_mode == 3'd1) begin
              st_next.out_level = 1'b0;
            end
          end
        end
      end
      OP_TICK: st_next = settle(st, 16'd1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= CTR_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  assign out_level = st_next.out_level;

endmodule

>>> sv/three_channel_interval_timer.sv
// Three-channel interval timer. A result appears in the cycle after its
// transaction is accepted. One transaction per cycle while the output is not
// stalled, set by each counter's single update pass into its state registers.
// A result waiting in the output register does not block the next input while
// the sink takes it in the same cycle. Synchronous reset puts every counter in
// mode 0, low-then-high access, output low, and empties the output register.
module three_channel_interval_timer #(
  parameter int NUM_COUNTERS = 3
) (
  input logic clk,
  input logic rst,
  itc_in_if.sink in,
  itc_out_if.source out
);
  import itc_pkg::*;

  logic accept;
  ctr_op_t ops [NUM_COUNTERS];
  logic [7:0] rd_bytes [NUM_COUNTERS];
  logic [2:0] levels;
  logic [7:0] rd_sel;

  assign in.ready = !out.valid || out.ready;
  assign accept = in.valid && in.ready;

  for (genvar i = 0; i < NUM_COUNTERS; i++) begin : g_ctr
    localparam logic [1:0] IDX = 2'(i);
    logic [7:0] rd_i;
    logic lvl_i;

    always_comb begin
      ops[i].kind = OP_NONE;
      ops[i].data = in.wr_data;
      ops[i].gate = in.gate_value;
      case (in.cmd)
        CMD_READ: if (in.port == IDX) ops[i].kind = OP_READ;
        CMD_WRITE: begin
          if (in.port == CTRL_PORT) begin
            if (in.wr_data[7:6] == SEL_READBACK) begin
              if (in.wr_data[i+1]) ops[i].kind = OP_READBACK;
            end else if (in.wr_data[7:6] == IDX) begin
              ops[i].kind = OP_CTRL;
            end
          end else if (in.port == IDX) begin
            ops[i].kind = OP_WRITE;
          end
        end
        CMD_GATE: if (in.gate_select == IDX) ops[i].kind = OP_GATE;
        CMD_TICK: ops[i].kind = OP_TICK;
        default: ;
      endcase
    end

    itc_counter u_ctr (
      .clk(clk), .rst(rst), .accept(accept), .op(ops[i]),
      .rd_byte(rd_i), .out_level(lvl_i)
    );

    assign rd_bytes[i] = rd_i;
    assign levels[i] = lvl_i;
  end

  if (NUM_COUNTERS < 3) begin : g_pad
    assign levels[2:NUM_COUNTERS] = '0;
  end

  always_comb begin
    rd_sel = 8'hff;
    for (int k = 0; k < NUM_COUNTERS; k++) begin
      if (in.cmd == CMD_READ && in.port == 2'(k)) begin
        rd_sel = rd_bytes[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (accept) begin
      out.valid <= 1'b1;
    end else if (out.ready) begin
      out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out.rd_data <= rd_sel;
      out.out_levels <= levels;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out.valid) else $error("accepted transaction produced no result");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.ready && !accept |=> !out.valid)
    else $error("result repeated after it was taken");
  a_no_read_ff: assert property (@(posedge clk) disable iff (rst)
    accept && in.cmd != CMD_READ |=> out.rd_data == 8'hff)
    else $error("non-read transaction returned data");
  a_levels_range: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> (out.out_levels >> NUM_COUNTERS) == 3'd0)
    else $error("output level set for an absent counter");

endmodule
